// ===== rtl/knnwr_pkg.sv =====
package knnwr_pkg;

  localparam int DIST_W    = 18;
  localparam int PROB_W    = 14;
  localparam int CFG_W     = 5;
  localparam int W_BITS    = 64;
  localparam int DCNT_W    = 7;
  localparam logic [CFG_W-1:0]  NBR_RESET = 5'd3;
  localparam logic [PROB_W-1:0] PROB_FULL = 14'd10000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_INIT,
    S_SCAN,
    S_PICK,
    S_CUBE,
    S_WDIV_INIT,
    S_WDIV,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC_HI,
    S_NEXT,
    S_FDIV_INIT,
    S_FDIV,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_SCAN_INIT,
    CMD_SCAN,
    CMD_PICK,
    CMD_CUBE,
    CMD_WDIV_INIT,
    CMD_DIV_STEP,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_ACC_HI,
    CMD_FDIV_INIT,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pick_zero;
    logic div_done;
    logic passes_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/knnwr_ctrl.sv =====
module knnwr_ctrl
  import knnwr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_valid && in_last) state_nxt = S_START;
      S_START:     state_nxt = S_SCAN_INIT;
      S_SCAN_INIT: state_nxt = S_SCAN;
      S_SCAN:      if (status.scan_done) state_nxt = S_PICK;
      S_PICK:      state_nxt = status.pick_zero ? S_NEXT : S_CUBE;
      S_CUBE:      state_nxt = S_WDIV_INIT;
      S_WDIV_INIT: state_nxt = S_WDIV;
      S_WDIV:      if (status.div_done) state_nxt = S_MUL_LO;
      S_MUL_LO:    state_nxt = S_MUL_HI;
      S_MUL_HI:    state_nxt = S_ACC_HI;
      S_ACC_HI:    state_nxt = S_NEXT;
      S_NEXT:      state_nxt = status.passes_done ? S_FDIV_INIT : S_SCAN_INIT;
      S_FDIV_INIT: state_nxt = S_FDIV;
      S_FDIV:      if (status.div_done) state_nxt = S_OUT;
      S_OUT:       if (status.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = CMD_NONE;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_START:     cmd = CMD_START;
      S_SCAN_INIT: cmd = CMD_SCAN_INIT;
      S_SCAN:      cmd = CMD_SCAN;
      S_PICK:      cmd = CMD_PICK;
      S_CUBE:      cmd = CMD_CUBE;
      S_WDIV_INIT: cmd = CMD_WDIV_INIT;
      S_WDIV:      cmd = CMD_DIV_STEP;
      S_MUL_LO:    cmd = CMD_MUL_LO;
      S_MUL_HI:    cmd = CMD_MUL_HI;
      S_ACC_HI:    cmd = CMD_ACC_HI;
      S_FDIV_INIT: cmd = CMD_FDIV_INIT;
      S_FDIV:      cmd = CMD_DIV_STEP;
      S_OUT:       cmd = status.out_free ? CMD_OUT : CMD_NONE;
      default:     cmd = CMD_NONE;
    endcase
  end

endmodule

// ===== rtl/knnwr_dp.sv =====
module knnwr_dp
  import knnwr_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 256,
  parameter int K_MAX        = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              load,
  input  logic [DIST_W-1:0] load_dist,
  input  logic [PROB_W-1:0] load_prob,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PROB_W-1:0] out_estimate,
  output logic              out_exact_match
);

  localparam int AW    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CW    = $clog2(SAMPLE_DEPTH + 1);
  localparam int KW    = $clog2(K_MAX + 1);
  localparam int ZP_W  = PROB_W + KW;
  localparam int WS_W  = W_BITS + KW;
  localparam int WPS_W = WS_W + PROB_W;

  logic [DIST_W-1:0] dist_mem [SAMPLE_DEPTH];
  logic [PROB_W-1:0] prob_mem [SAMPLE_DEPTH];

  logic [CFG_W-1:0]  nbr_r;
  logic [CW-1:0]     cnt_r;
  logic [KW-1:0]     k_r, pass_r, zcnt_r;
  logic [ZP_W-1:0]   zprob_r;
  logic [CW-1:0]     addr_r;
  logic              rd_v_r;
  logic [AW-1:0]     rd_idx_r, best_idx_r, prev_idx_r;
  logic [DIST_W-1:0] rd_d_r, best_d_r, prev_d_r;
  logic [PROB_W-1:0] rd_p_r, best_p_r;
  logic              best_v_r, prev_v_r;
  logic [2*DIST_W-1:0] r2_r;
  logic [3*DIST_W-1:0] r3_r;
  logic [WS_W-1:0]   rem_r, den_r, ws_r;
  logic [W_BITS-1:0] low_r, q_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [45:0]       plo_r, phi_r;
  logic [WPS_W-1:0]  wps_r;
  logic              out_valid_r;
  logic [PROB_W-1:0] est_r;
  logic              exact_r;

  logic [PROB_W-1:0] prob_sat;
  logic [KW-1:0]     k_nxt;
  logic              after_prev, before_best;
  logic [WS_W:0]     div_t, div_d;
  logic              div_ge;
  logic [WS_W-1:0]   rem_nxt;
  logic [PROB_W-1:0] est_nxt;

  assign prob_sat = (load_prob > PROB_FULL) ? PROB_FULL : load_prob;

  always_comb begin
    int kc;
    kc = (nbr_r == '0) ? 1 : int'(nbr_r);
    if (kc > K_MAX) kc = K_MAX;
    if (kc > int'(cnt_r)) kc = int'(cnt_r);
    k_nxt = KW'(kc);
  end

  // ordering on (distance, index): earlier sample wins on equal distance
  assign after_prev  = !prev_v_r || ({rd_d_r, rd_idx_r} > {prev_d_r, prev_idx_r});
  assign before_best = !best_v_r || ({rd_d_r, rd_idx_r} < {best_d_r, best_idx_r});

  assign div_t   = {rem_r, low_r[W_BITS-1]};
  assign div_d   = {1'b0, den_r};
  assign div_ge  = (div_t >= div_d);
  assign rem_nxt = div_ge ? WS_W'(div_t - div_d) : div_t[WS_W-1:0];

  assign est_nxt = (q_r > W_BITS'(PROB_FULL)) ? PROB_FULL : q_r[PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (load && (cnt_r < CW'(SAMPLE_DEPTH))) begin
      dist_mem[cnt_r[AW-1:0]] <= load_dist;
      prob_mem[cnt_r[AW-1:0]] <= prob_sat;
    end
    if (cmd == CMD_SCAN) begin
      rd_d_r   <= dist_mem[addr_r[AW-1:0]];
      rd_p_r   <= prob_mem[addr_r[AW-1:0]];
      rd_idx_r <= addr_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbr_r       <= NBR_RESET;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      best_v_r    <= 1'b0;
      prev_v_r    <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) nbr_r <= cfg_wr_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (load && (cnt_r < CW'(SAMPLE_DEPTH))) cnt_r <= cnt_r + 1'b1;
      case (cmd)
        CMD_START: begin
          k_r      <= k_nxt;
          pass_r   <= '0;
          zcnt_r   <= '0;
          zprob_r  <= '0;
          ws_r     <= '0;
          wps_r    <= '0;
          prev_v_r <= 1'b0;
        end
        CMD_SCAN_INIT: begin
          addr_r   <= '0;
          rd_v_r   <= 1'b0;
          best_v_r <= 1'b0;
        end
        CMD_SCAN: begin
          if (addr_r < cnt_r) begin
            addr_r <= addr_r + 1'b1;
            rd_v_r <= 1'b1;
          end else begin
            rd_v_r <= 1'b0;
          end
          if (rd_v_r && after_prev && before_best) begin
            best_v_r   <= 1'b1;
            best_d_r   <= rd_d_r;
            best_p_r   <= rd_p_r;
            best_idx_r <= rd_idx_r;
          end
        end
        CMD_PICK: begin
          prev_v_r   <= 1'b1;
          prev_d_r   <= best_d_r;
          prev_idx_r <= best_idx_r;
          pass_r     <= pass_r + 1'b1;
          if (best_d_r == '0) begin
            zcnt_r  <= zcnt_r + 1'b1;
            zprob_r <= zprob_r + ZP_W'(best_p_r);
          end
          r2_r <= (2*DIST_W)'(best_d_r) * (2*DIST_W)'(best_d_r);
        end
        CMD_CUBE: r3_r <= (3*DIST_W)'(r2_r) * (3*DIST_W)'(best_d_r);
        CMD_WDIV_INIT: begin
          rem_r  <= '0;
          low_r  <= '1;
          den_r  <= WS_W'(r3_r);
          q_r    <= '0;
          dcnt_r <= DCNT_W'(W_BITS);
        end
        CMD_DIV_STEP: begin
          if (dcnt_r != '0) begin
            rem_r  <= rem_nxt;
            low_r  <= {low_r[W_BITS-2:0], 1'b0};
            q_r    <= {q_r[W_BITS-2:0], div_ge};
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        CMD_MUL_LO: plo_r <= 46'(q_r[31:0]) * 46'(best_p_r);
        CMD_MUL_HI: begin
          phi_r <= 46'(q_r[63:32]) * 46'(best_p_r);
          wps_r <= wps_r + WPS_W'(plo_r);
          ws_r  <= ws_r + WS_W'(q_r);
        end
        CMD_ACC_HI: wps_r <= wps_r + (WPS_W'(phi_r) << 32);
        CMD_FDIV_INIT: begin
          q_r <= '0;
          if (zcnt_r != '0) begin
            rem_r  <= '0;
            low_r  <= {zprob_r, {(W_BITS-ZP_W){1'b0}}};
            den_r  <= WS_W'(zcnt_r);
            dcnt_r <= DCNT_W'(ZP_W);
          end else begin
            // mean is at most PROB_FULL, so only the low quotient bits are live
            rem_r  <= wps_r[WPS_W-1:PROB_W];
            low_r  <= {wps_r[PROB_W-1:0], {(W_BITS-PROB_W){1'b0}}};
            den_r  <= ws_r;
            dcnt_r <= DCNT_W'(PROB_W);
          end
        end
        CMD_OUT: begin
          out_valid_r <= 1'b1;
          est_r       <= est_nxt;
          exact_r     <= (zcnt_r != '0);
          cnt_r       <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.scan_done   = (addr_r == cnt_r) && !rd_v_r;
    status.pick_zero   = (best_d_r == '0);
    status.div_done    = (dcnt_r == '0);
    status.passes_done = (pass_r == k_r);
    status.out_free    = !out_valid_r;
  end

  assign out_valid       = out_valid_r;
  assign out_estimate    = est_r;
  assign out_exact_match = exact_r;

endmodule

// ===== rtl/knn_weighted_regression_top.sv =====
// channel  direction  transfer when           payload
// in_      input      in_valid & !in_stall    sample_distance, sample_probability, last_sample
// out_     output     out_valid & !out_stall  estimate, exact_match
// cfg_     input      cfg_wr_en               neighbour_count
//
// Samples load at one per cycle while in_stall is low. A last_sample transfer starts the estimate:
// a set-up state, then per pick a sweep over the loaded samples and the pick, and for
// non-zero distance the cube, the bit-serial reciprocal divider and the weight multiply-accumulate;
// then a final divide and a register for the result.
// in_stall is high for all of this. Reset is synchronous; no clearing pass.
// The result waits in the output register while out_stall is high.
module knn_weighted_regression_top
  import knnwr_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 256,
  parameter int K_MAX        = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DIST_W-1:0] in_sample_distance,
  input  logic [PROB_W-1:0] in_sample_probability,
  input  logic              in_last_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PROB_W-1:0] out_estimate,
  output logic              out_exact_match
);

  cmd_t    cmd;
  status_t status;
  logic    busy;

  assign in_stall = busy;

  knnwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last_sample),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  knnwr_dp #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .K_MAX        (K_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .load            (in_valid && !busy),
    .load_dist       (in_sample_distance),
    .load_prob       (in_sample_probability),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_estimate    (out_estimate),
    .out_exact_match (out_exact_match)
  );

endmodule

// ===== rtl/knnwr_chk.sv =====
module knnwr_chk
  import knnwr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_last_sample,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PROB_W-1:0] out_estimate
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_estimate))
    else $error("estimate changed while stalled");

  a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_estimate <= PROB_FULL)
    else $error("estimate above full scale");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_sample |=> in_stall)
    else $error("input taken during estimate");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind knn_weighted_regression_top knnwr_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_sample (in_last_sample),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_estimate   (out_estimate)
);

// ===== verif/knn_weighted_regression_top_tb.sv =====
`timescale 1ns / 1ps

module knn_weighted_regression_top_tb;
  import knnwr_pkg::*;

  localparam int DEPTH     = 256;
  localparam int KCAP      = 16;
  localparam int CYCLE_CAP = 4000000;

  typedef struct {
    logic [PROB_W-1:0] estimate;
    logic              exact;
  } estimate_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DIST_W-1:0] in_sample_distance = '0;
  logic [PROB_W-1:0] in_sample_probability = '0;
  logic              in_last_sample = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PROB_W-1:0] out_estimate;
  logic              out_exact_match;

  knn_weighted_regression_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample_distance   (in_sample_distance),
    .in_sample_probability(in_sample_probability),
    .in_last_sample       (in_last_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_estimate         (out_estimate),
    .out_exact_match      (out_exact_match)
  );

  // predictor state
  logic [DIST_W-1:0] nn_dist [DEPTH];
  logic [PROB_W-1:0] nn_prob [DEPTH];
  int unsigned       nn_loaded = 0;
  logic [CFG_W-1:0]  k_setting = NBR_RESET;

  estimate_t   estimate_q[$];
  int          errors = 0;
  int          samples_sent = 0;
  int          estimates_seen = 0;
  int          exact_seen = 0;
  int          cycles = 0;
  int          hold_left = 0;
  bit          quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout at %0t", $time);
      $display("knn_weighted_regression_top test failed");
      $finish;
    end
  end

  // receiver: long hold-off when requested, no stalls when quiet, otherwise random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  // inverse-cube weighted estimate over the k nearest loaded samples
  function automatic void predict_sample(input logic [DIST_W-1:0] d, input logic [PROB_W-1:0] p,
                                         input logic last);
    int unsigned       k, zero_cnt, zero_sum, best, pass, i;
    bit                found;
    bit                picked [DEPTH];
    logic [63:0]       r, w;
    logic [67:0]       w_total;
    logic [127:0]      wp_total, quot;
    estimate_t         e;
    if (nn_loaded < DEPTH) begin
      nn_dist[nn_loaded] = d;
      nn_prob[nn_loaded] = (p > PROB_FULL) ? PROB_FULL : p;
      nn_loaded++;
    end
    if (!last) return;
    k = 32'(k_setting);
    if (k == 0) k = 1;
    if (k > KCAP) k = KCAP;
    if (k > nn_loaded) k = nn_loaded;
    for (i = 0; i < DEPTH; i++) picked[i] = 1'b0;
    zero_cnt = 0;
    zero_sum = 0;
    w_total = '0;
    wp_total = '0;
    for (pass = 0; pass < k; pass++) begin
      found = 1'b0;
      best = 0;
      for (i = 0; i < nn_loaded; i++) begin
        if (!picked[i] && (!found || nn_dist[i] < nn_dist[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      picked[best] = 1'b1;
      if (nn_dist[best] == 0) begin
        zero_cnt++;
        zero_sum += 32'(nn_prob[best]);
      end else begin
        r = 64'(nn_dist[best]);
        w = 64'hFFFF_FFFF_FFFF_FFFF / (r * r * r);
        w_total += {4'b0, w};
        wp_total += {64'b0, w} * {114'b0, nn_prob[best]};
      end
    end
    if (zero_cnt > 0) quot = 128'(zero_sum / zero_cnt);
    else if (w_total == 0) quot = '0;
    else quot = wp_total / {60'b0, w_total};
    if (quot > PROB_FULL) quot = 128'(PROB_FULL);
    e.estimate = quot[PROB_W-1:0];
    e.exact = (zero_cnt > 0);
    estimate_q.push_back(e);
    nn_loaded = 0;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (estimate_q.size() == 0) begin
        $display("%0t: unexpected result estimate=%0d exact=%0b", $time, out_estimate,
                 out_exact_match);
        errors++;
      end else begin
        if (out_estimate !== estimate_q[0].estimate) begin
          $display("%0t: estimate mismatch expected %0d actual %0d", $time,
                   estimate_q[0].estimate, out_estimate);
          errors++;
        end
        if (out_exact_match !== estimate_q[0].exact) begin
          $display("%0t: exact_match mismatch expected %0b actual %0b", $time,
                   estimate_q[0].exact, out_exact_match);
          errors++;
        end
        if (estimate_q[0].exact) exact_seen++;
        void'(estimate_q.pop_front());
        estimates_seen++;
      end
    end
  end

  task automatic send_sample(input logic [DIST_W-1:0] d, input logic [PROB_W-1:0] p,
                             input logic last);
    if (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_distance <= d;
    in_sample_probability <= p;
    in_last_sample <= last;
    do @(posedge clk); while (in_stall);
    predict_sample(d, p, last);
    samples_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (estimate_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_neighbours(input logic [CFG_W-1:0] v);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    k_setting = v;
  endtask

  function automatic logic [DIST_W-1:0] rand_distance();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 40) return DIST_W'($urandom_range(1, 15));
    if (sel < 50) return DIST_W'($urandom_range(1, 3) << $urandom_range(0, 16));
    return DIST_W'($urandom_range(0, (1 << DIST_W) - 1));
  endfunction

  function automatic logic [PROB_W-1:0] rand_probability();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return PROB_W'($urandom_range(10001, (1 << PROB_W) - 1));
    if (sel < 10) return PROB_FULL;
    return PROB_W'($urandom_range(0, PROB_FULL));
  endfunction

  task automatic send_query(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_sample(rand_distance(), rand_probability(), i == n - 1);
  endtask

  function automatic int unsigned rand_size();
    return ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
  endfunction

  task automatic test_directed();
    // reset k of three
    send_sample(18'd0, 14'd10000, 1'b0);
    send_sample(18'd0, 14'd9999, 1'b1);
    send_sample(18'h3FFFF, 14'h3FFF, 1'b1);
    // equal distances: earlier samples win
    send_sample(18'd5, 14'd100, 1'b0);
    send_sample(18'd5, 14'd9000, 1'b0);
    send_sample(18'd5, 14'd0, 1'b0);
    send_sample(18'd5, 14'd7777, 1'b1);
    // zero distance outweighs everything else
    send_sample(18'd1, 14'd10000, 1'b0);
    send_sample(18'd0, 14'd3, 1'b0);
    send_sample(18'd2, 14'd5000, 1'b1);
    // extreme spread of weights
    send_sample(18'd1, 14'd0, 1'b0);
    send_sample(18'h3FFFF, 14'd10000, 1'b0);
    send_sample(18'h20000, 14'd12000, 1'b1);
    // k of zero treated as one, k above the cap saturates
    set_neighbours(5'd0);
    send_sample(18'd9, 14'd1, 1'b0);
    send_sample(18'd8, 14'd2, 1'b1);
    set_neighbours(5'd31);
    for (int i = 0; i < 8; i++)
      send_sample(DIST_W'(100 - i), PROB_W'(1000 * i), i == 7);
    wait_drain();
  endtask

  task automatic test_k_sweep();
    logic [CFG_W-1:0] ks [6] = '{5'd1, 5'd16, 5'd17, 5'd2, 5'd0, 5'd31};
    foreach (ks[j]) begin
      set_neighbours(ks[j]);
      repeat (4) send_query(rand_size());
    end
    wait_drain();
  endtask

  task automatic test_store_full();
    set_neighbours(5'd16);
    send_query(300);
    set_neighbours(5'd5);
    send_query(257);
    wait_drain();
  endtask

  task automatic test_backpressure();
    set_neighbours(5'd2);
    hold_left = 3000;
    repeat (6) send_query($urandom_range(1, 4));
    wait_drain();
  endtask

  task automatic test_random();
    int unsigned q;
    q = 0;
    while (samples_sent < 1250) begin
      if (q % 20 == 0) set_neighbours(CFG_W'($urandom_range(0, 31)));
      quiet = (q >= 60 && q < 80);
      send_query(rand_size());
      if (q % 37 == 36) wait_drain();
      q++;
    end
    quiet = 1'b0;
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_k_sweep();
    test_store_full();
    test_backpressure();
    test_random();
    repeat (200) @(posedge clk);
    $display("sent %0d samples, checked %0d estimates (%0d exact matches)", samples_sent,
             estimates_seen, exact_seen);
    $display("covered k from 0 to 31, ties, zero distances, full store and long output stall");
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("knn_weighted_regression_top test passed");
    end else begin
      $display("%0d errors, %0d estimates outstanding", errors, estimate_q.size());
      $display("knn_weighted_regression_top test failed");
    end
    $finish;
  end

endmodule
